@@ hdl/wnms_pkg.sv @@
`default_nettype none

package wnms_pkg;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int ROW_W      = 10;
  localparam int COL_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int HALF_CFG_W = 3;

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // parameter defaults
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HALF_DEF  = 4;

  // frame limits and register reset values
  localparam int HEIGHT_LIMIT = 1024;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int HALF_RESET   = 3;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_HALF_WINDOW  = 2'd2
  } reg_idx_t;

  // one window column as it travels down the cell chain
  typedef struct packed {
    pix_t col_max;
    pix_t center;
  } col_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/wnms_if.sv @@
`default_nettype none

interface wnms_pix_if;
  logic              valid;
  logic              ready;
  wnms_pkg::pix_t    pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface wnms_res_if;
  logic                          valid;
  logic                          ready;
  logic [wnms_pkg::ROW_W-1:0]    out_row;
  logic [wnms_pkg::COL_W-1:0]    out_col;
  wnms_pkg::pix_t                out_value;
  logic                          frame_last;

  modport source (output valid, output out_row, output out_col, output out_value,
                  output frame_last, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_value,
                  input frame_last, output ready);
endinterface

`default_nettype wire

@@ hdl/window_non_maxima_suppression.sv @@
// Square-window non-maximum suppression over a raster stream of 8-bit responses.
// in_pix takes one pixel per transfer in raster order (rows top to bottom, each
// left to right); out_res gives one result for every interior pixel: row, column,
// value (kept if nonzero and no window pixel is strictly greater, else zero) and
// frame_last on the last interior pixel of the frame. Border pixels give no transfer.
// Throughput is one pixel per clock while out_res is not stalled; the pixel that
// completes a window passes through line bank read, row alignment, column max into
// the cell chain, and window max and compare into the output register.
// Line banks hold 2*MAX_HALF previous rows of MAX_WIDTH pixels; a chain of
// 2*MAX_HALF+1 cells holds the column maxima of the window.
// cfg_* is an APB-style port, registers at 0x0 width, 0x4 height, 0x8 half window;
// any write of them restarts the frame at row 0, column 0. pready is always high.
// Reset sets 640 x 480 with half window 3 and position 0,0; no clearing pass is
// needed, since every line read within a frame was written earlier in that frame.
// When out_res stalls, the whole pipeline holds and in_pix.ready drops in the
// same cycle; an output register holds the waiting result.
`default_nettype none

module window_non_maxima_suppression #(
  parameter int MAX_WIDTH = wnms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF  = wnms_pkg::MAX_HALF_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  wnms_pix_if.sink                                 in_pix,
  wnms_res_if.source                               out_res,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [wnms_pkg::APB_ADDR_W-1:0]     cfg_paddr,
  input  wire logic [wnms_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic      [wnms_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                                     cfg_pready
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int NB    = 2 * MAX_HALF;
  localparam int CELLS = NB + 1;
  localparam int HW    = $clog2(MAX_HALF + 1);
  localparam int PW    = $clog2(NB);
  localparam int CIW   = $clog2(CELLS);
  localparam int RW    = wnms_pkg::ROW_W;
  localparam int SW    = wnms_pkg::SIZE_W;
  localparam int PXW   = wnms_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // effective sizes, saturated once at write time
  // ---------------------------------------------------------------------------
  function automatic logic [CW-1:0] w_last_of(input logic [SW-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_WIDTH) begin
      res = CW'(MAX_WIDTH - 1);
    end else begin
      res = CW'(v - SW'(1));
    end
    return res;
  endfunction

  function automatic logic [RW-1:0] h_last_of(input logic [SW-1:0] v);
    logic [RW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > wnms_pkg::HEIGHT_LIMIT) begin
      res = RW'(wnms_pkg::HEIGHT_LIMIT - 1);
    end else begin
      res = RW'(v - SW'(1));
    end
    return res;
  endfunction

  function automatic logic [HW-1:0] half_of(input logic [wnms_pkg::HALF_CFG_W-1:0] v);
    logic [HW-1:0] res;
    if (int'(v) > MAX_HALF) begin
      res = HW'(MAX_HALF);
    end else begin
      res = HW'(v);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [SW-1:0]                     width_r;
  logic [SW-1:0]                     height_r;
  logic [wnms_pkg::HALF_CFG_W-1:0]   half_r;
  logic [CW-1:0]                     w_last_r;
  logic [RW-1:0]                     h_last_r;
  logic [HW-1:0]                     hh_r;

  logic                cfg_wr;
  logic                cfg_restart;
  wnms_pkg::reg_idx_t  cfg_idx;

  assign cfg_pready  = 1'b1;
  assign cfg_idx     = wnms_pkg::reg_idx_t'(cfg_paddr[wnms_pkg::APB_ADDR_W-1:2]);
  assign cfg_wr      = cfg_psel & cfg_penable & cfg_pwrite;
  // only the defined registers restart the frame
  assign cfg_restart = cfg_wr && ((cfg_idx == wnms_pkg::REG_IMAGE_WIDTH) ||
                                  (cfg_idx == wnms_pkg::REG_IMAGE_HEIGHT) ||
                                  (cfg_idx == wnms_pkg::REG_HALF_WINDOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SW'(wnms_pkg::WIDTH_RESET);
      height_r <= SW'(wnms_pkg::HEIGHT_RESET);
      half_r   <= wnms_pkg::HALF_CFG_W'(wnms_pkg::HALF_RESET);
      w_last_r <= w_last_of(SW'(wnms_pkg::WIDTH_RESET));
      h_last_r <= h_last_of(SW'(wnms_pkg::HEIGHT_RESET));
      hh_r     <= half_of(wnms_pkg::HALF_CFG_W'(wnms_pkg::HALF_RESET));
    end else if (cfg_wr) begin
      case (cfg_idx)
        wnms_pkg::REG_IMAGE_WIDTH: begin
          width_r  <= cfg_pwdata[SW-1:0];
          w_last_r <= w_last_of(cfg_pwdata[SW-1:0]);
        end
        wnms_pkg::REG_IMAGE_HEIGHT: begin
          height_r <= cfg_pwdata[SW-1:0];
          h_last_r <= h_last_of(cfg_pwdata[SW-1:0]);
        end
        wnms_pkg::REG_HALF_WINDOW: begin
          half_r <= cfg_pwdata[wnms_pkg::HALF_CFG_W-1:0];
          hh_r   <= half_of(cfg_pwdata[wnms_pkg::HALF_CFG_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // register readback shows the raw written values
  always_comb begin
    case (cfg_idx)
      wnms_pkg::REG_IMAGE_WIDTH:  cfg_prdata = wnms_pkg::APB_DATA_W'(width_r);
      wnms_pkg::REG_IMAGE_HEIGHT: cfg_prdata = wnms_pkg::APB_DATA_W'(height_r);
      wnms_pkg::REG_HALF_WINDOW:  cfg_prdata = wnms_pkg::APB_DATA_W'(half_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: every stage moves together whenever the output register is free
  // ---------------------------------------------------------------------------
  logic adv;
  logic in_acc;
  logic out_valid_r;

  assign adv          = !out_valid_r || out_res.ready;
  assign in_pix.ready = adv;
  assign in_acc       = adv && in_pix.valid;

  // ---------------------------------------------------------------------------
  // raster position and line bank pointer
  // ---------------------------------------------------------------------------
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [PW-1:0] ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      ptr_r <= '0;
    end else if (cfg_restart) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      if (col_r == w_last_r) begin
        col_r <= '0;
        row_r <= (row_r == h_last_r) ? '0 : row_r + RW'(1);
        // bank pointer runs on across frames, only row age matters
        ptr_r <= (ptr_r == PW'(NB - 1)) ? '0 : ptr_r + PW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // window complete once 2h rows and 2h columns precede this pixel
  logic emit_now;
  logic last_now;

  assign emit_now = (int'(row_r) >= 2 * int'(hh_r)) && (int'(col_r) >= 2 * int'(hh_r));
  assign last_now = (row_r == h_last_r) && (col_r == w_last_r);

  // ---------------------------------------------------------------------------
  // line banks
  // ---------------------------------------------------------------------------
  wnms_pkg::mem_ctrl_t        lb_ctrl;
  logic [NB-1:0][PXW-1:0]     lb_rows;

  assign lb_ctrl.wr_en = in_acc;
  assign lb_ctrl.rd_en = adv;

  wnms_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HALF  (MAX_HALF)
  ) u_line_buf (
    .clk       (clk),
    .ctrl_i    (lb_ctrl),
    .wr_ptr_i  (ptr_r),
    .addr_i    (col_r),
    .wr_data_i (in_pix.pixel_value),
    .rows_o    (lb_rows)
  );

  // ---------------------------------------------------------------------------
  // stage 1: pixel and center position, bank reads in flight
  // ---------------------------------------------------------------------------
  logic           s1_vld_r;
  logic           s1_emit_r;
  logic           s1_last_r;
  wnms_pkg::pix_t s1_pix_r;
  logic [RW-1:0]  s1_row_r;
  logic [CW-1:0]  s1_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit_r <= emit_now;
      s1_last_r <= last_now;
      s1_pix_r  <= in_pix.pixel_value;
      s1_row_r  <= row_r - RW'(hh_r);
      s1_col_r  <= col_r - CW'(hh_r);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: rows of the current column ordered by age, outside rows zeroed
  // ---------------------------------------------------------------------------
  logic [CELLS-1:0][PXW-1:0] rows_nxt;
  logic [CELLS-1:0][PXW-1:0] s2_rows_r;
  wnms_pkg::pix_t            s2_ctr_r;
  logic                      s2_vld_r;
  logic                      s2_emit_r;
  logic                      s2_last_r;
  logic [RW-1:0]             s2_row_r;
  logic [CW-1:0]             s2_col_r;

  always_comb begin
    rows_nxt[0] = s1_pix_r;
    for (int a = 1; a < CELLS; a++) begin
      rows_nxt[a] = (a <= 2 * int'(hh_r)) ? lb_rows[a-1] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_rows_r <= rows_nxt;
      s2_ctr_r  <= rows_nxt[CIW'(hh_r)];
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: column max enters the cell chain; cell k holds column c-k
  // ---------------------------------------------------------------------------
  wnms_pkg::pix_t            col_max;
  wnms_pkg::col_t            col_new;
  wnms_pkg::col_t            cell_q   [CELLS];
  logic [CELLS-1:0][PXW-1:0] cell_max;
  logic                      shift;

  wnms_max_tree #(
    .N (CELLS)
  ) u_col_max (
    .d_i   (s2_rows_r),
    .max_o (col_max)
  );

  assign col_new.col_max = col_max;
  assign col_new.center  = s2_ctr_r;
  // bubbles do not move the chain, so it always holds the last columns of the row
  assign shift           = adv && s2_vld_r;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    wnms_pkg::col_t d_k;
    logic           act_k;

    if (k == 0) begin : g_head
      assign d_k = col_new;
    end else begin : g_link
      assign d_k = cell_q[k-1];
    end

    assign act_k = (k <= 2 * int'(hh_r));

    wnms_cell u_cell (
      .clk      (clk),
      .shift_i  (shift),
      .active_i (act_k),
      .d_i      (d_k),
      .q_o      (cell_q[k]),
      .max_o    (cell_max[k])
    );
  end

  logic          s3_vld_r;
  logic          s3_emit_r;
  logic          s3_last_r;
  logic [RW-1:0] s3_row_r;
  logic [CW-1:0] s3_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_emit_r <= s2_emit_r;
      s3_last_r <= s2_last_r;
      s3_row_r  <= s2_row_r;
      s3_col_r  <= s2_col_r;
    end
  end

  // ---------------------------------------------------------------------------
  // window max and decision into the output register
  // ---------------------------------------------------------------------------
  wnms_pkg::pix_t win_max;
  wnms_pkg::pix_t center;
  logic           keep;

  wnms_max_tree #(
    .N (CELLS)
  ) u_win_max (
    .d_i   (cell_max),
    .max_o (win_max)
  );

  assign center = cell_q[CIW'(hh_r)].center;
  // the window includes the center, so ties leave win_max equal to it
  assign keep   = (center != '0) && (win_max <= center);

  logic [RW-1:0]              out_row_r;
  logic [wnms_pkg::COL_W-1:0] out_col_r;
  wnms_pkg::pix_t             out_value_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_vld_r && s3_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_row_r   <= s3_row_r;
      out_col_r   <= wnms_pkg::COL_W'(s3_col_r);
      out_value_r <= keep ? center : '0;
      out_last_r  <= s3_last_r;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.out_row    = out_row_r;
  assign out_res.out_col    = out_col_r;
  assign out_res.out_value  = out_value_r;
  assign out_res.frame_last = out_last_r;

`ifndef SYNTHESIS
  // raster position never leaves the configured frame
  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= w_last_r) && (row_r <= h_last_r))
    else $error("raster position outside frame");

  // a new result only comes from an emitting item in the last stage
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s3_vld_r && s3_emit_r))
    else $error("result without emitting item");

  // whenever the cell chain moves, a valid column enters the last stage
  a_chain_step: assert property (@(posedge clk) disable iff (!rst_n)
    shift |=> s3_vld_r)
    else $error("cell chain shifted without an item");
`endif

endmodule

`default_nettype wire

@@ hdl/wnms_max_tree.sv @@
`default_nettype none

module wnms_max_tree #(
  parameter int N = 2 * wnms_pkg::MAX_HALF_DEF + 1
) (
  input  wire logic [N-1:0][wnms_pkg::PIX_W-1:0] d_i,
  output logic      [wnms_pkg::PIX_W-1:0]        max_o
);

  localparam int NP = 1 << $clog2(N);

  logic [NP-1:0][wnms_pkg::PIX_W-1:0] v;

  // balanced pairwise reduction, zero padded up to a power of two
  always_comb begin
    v = '0;
    for (int i = 0; i < N; i++) begin
      v[i] = d_i[i];
    end
    for (int s = NP >> 1; s >= 1; s = s >> 1) begin
      for (int i = 0; i < s; i++) begin
        v[i] = (v[2*i] > v[2*i+1]) ? v[2*i] : v[2*i+1];
      end
    end
  end

  assign max_o = v[0];

endmodule

`default_nettype wire

@@ hdl/wnms_cell.sv @@
`default_nettype none

module wnms_cell (
  input  wire logic           clk,
  input  wire logic           shift_i,
  input  wire logic           active_i,
  input  wire wnms_pkg::col_t d_i,
  output wnms_pkg::col_t      q_o,
  output wnms_pkg::pix_t      max_o
);

  wnms_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (shift_i) begin
      col_r <= d_i;
    end
  end

  assign q_o   = col_r;
  // columns outside the current window count as zero
  assign max_o = active_i ? col_r.col_max : '0;

endmodule

`default_nettype wire

@@ hdl/wnms_line_buf.sv @@
`default_nettype none

module wnms_line_buf #(
  parameter int MAX_WIDTH = wnms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HALF  = wnms_pkg::MAX_HALF_DEF
) (
  input  wire logic                                        clk,
  input  wire wnms_pkg::mem_ctrl_t                         ctrl_i,
  input  wire logic [$clog2(2*MAX_HALF)-1:0]               wr_ptr_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]                addr_i,
  input  wire wnms_pkg::pix_t                              wr_data_i,
  output logic      [2*MAX_HALF-1:0][wnms_pkg::PIX_W-1:0]  rows_o
);

  localparam int NB = 2 * MAX_HALF;
  localparam int PW = $clog2(NB);

  logic [NB-1:0][wnms_pkg::PIX_W-1:0] rd_all;
  logic [PW-1:0]                      ptr_q_r;

  // one bank per stored row, read-first so the oldest row is seen before overwrite
  for (genvar b = 0; b < NB; b++) begin : g_bank
    wnms_pkg::pix_t mem [MAX_WIDTH];
    wnms_pkg::pix_t rd_r;

    always_ff @(posedge clk) begin
      if (ctrl_i.wr_en && (wr_ptr_i == PW'(b))) begin
        mem[addr_i] <= wr_data_i;
      end
      if (ctrl_i.rd_en) begin
        rd_r <= mem[addr_i];
      end
    end

    assign rd_all[b] = rd_r;
  end

  always_ff @(posedge clk) begin
    if (ctrl_i.rd_en) begin
      ptr_q_r <= wr_ptr_i;
    end
  end

  // reorder banks by row age: rows_o[a-1] is the row a lines above
  always_comb begin
    int idx;
    for (int a = 1; a <= NB; a++) begin
      idx = (int'(ptr_q_r) >= a) ? int'(ptr_q_r) - a : int'(ptr_q_r) + NB - a;
      rows_o[a-1] = rd_all[PW'(idx)];
    end
  end

endmodule

`default_nettype wire

@@ sim/nms_result_check.sv @@
`timescale 1ns / 100ps

module nms_result_check (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  wnms_pix_if                                  pix,
  wnms_res_if                                  res,
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic                            cfg_pready,
  input  wire logic [wnms_pkg::APB_ADDR_W-1:0] cfg_paddr,
  input  wire logic [wnms_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output int                                   fail_count,
  output int                                   open_count
);

  localparam int RING_ROWS = 2 * wnms_pkg::MAX_HALF_DEF + 1;
  localparam int LINE_LEN  = wnms_pkg::MAX_WIDTH_DEF;

  typedef struct packed {
    logic [wnms_pkg::ROW_W-1:0] row;
    logic [wnms_pkg::COL_W-1:0] col;
    wnms_pkg::pix_t             value;
    logic                       last;
  } peak_t;

  logic [wnms_pkg::SIZE_W-1:0]     width_reg;
  logic [wnms_pkg::SIZE_W-1:0]     height_reg;
  logic [wnms_pkg::HALF_CFG_W-1:0] half_reg;
  wnms_pkg::pix_t                  lines [RING_ROWS][LINE_LEN];
  int                              row_pos;
  int                              col_pos;
  int                              fails;
  peak_t                           peak_q [$];

  // store one pixel and queue the window verdict it completes, if any
  function automatic void predict_peak(wnms_pkg::pix_t v);
    int             w, ht, h, r, c, cy, cx, y, x;
    wnms_pkg::pix_t center;
    logic           keep;
    peak_t          p;
    w  = (width_reg == 0) ? 1 :
         (width_reg > LINE_LEN) ? LINE_LEN : int'(width_reg);
    ht = (height_reg == 0) ? 1 :
         (height_reg > wnms_pkg::HEIGHT_LIMIT) ? wnms_pkg::HEIGHT_LIMIT : int'(height_reg);
    h  = (half_reg > wnms_pkg::MAX_HALF_DEF) ? wnms_pkg::MAX_HALF_DEF : int'(half_reg);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= ht) row_pos = 0;
    r = row_pos;
    c = col_pos;
    lines[r % RING_ROWS][c] = v;
    if (r >= 2 * h && c >= 2 * h) begin
      cy = r - h;
      cx = c - h;
      center = lines[cy % RING_ROWS][cx];
      keep = (center != 0);
      for (y = r - 2 * h; y <= r; y++) begin
        for (x = c - 2 * h; x <= c; x++) begin
          if (lines[y % RING_ROWS][x] > center) keep = 1'b0;
        end
      end
      p.row   = wnms_pkg::ROW_W'(cy);
      p.col   = wnms_pkg::COL_W'(cx);
      p.value = keep ? center : '0;
      p.last  = (r == ht - 1) && (c == w - 1);
      peak_q.insert(peak_q.size(), p);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= ht) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  always @(posedge clk) begin : watch
    peak_t got;
    peak_t want;
    int    i;
    int    j;
    if (!rst_n) begin
      width_reg  = wnms_pkg::SIZE_W'(wnms_pkg::WIDTH_RESET);
      height_reg = wnms_pkg::SIZE_W'(wnms_pkg::HEIGHT_RESET);
      half_reg   = wnms_pkg::HALF_CFG_W'(wnms_pkg::HALF_RESET);
      row_pos    = 0;
      col_pos    = 0;
      fails      = 0;
      peak_q.delete();
      for (i = 0; i < RING_ROWS; i++) begin
        for (j = 0; j < LINE_LEN; j++) lines[i][j] = '0;
      end
    end else begin
      // register writes restart the frame
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (wnms_pkg::reg_idx_t'(cfg_paddr[wnms_pkg::APB_ADDR_W-1:2]))
          wnms_pkg::REG_IMAGE_WIDTH: begin
            width_reg = cfg_pwdata[wnms_pkg::SIZE_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          wnms_pkg::REG_IMAGE_HEIGHT: begin
            height_reg = cfg_pwdata[wnms_pkg::SIZE_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          wnms_pkg::REG_HALF_WINDOW: begin
            half_reg = cfg_pwdata[wnms_pkg::HALF_CFG_W-1:0];
            row_pos = 0;
            col_pos = 0;
          end
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        got = '{res.out_row, res.out_col, res.out_value, res.frame_last};
        if (peak_q.size() == 0) begin
          $error("unexpected result: row %0d col %0d value %0d",
                 got.row, got.col, got.value);
          fails++;
        end else begin
          want = peak_q.pop_front();
          if (got.row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, got.row);
            fails++;
          end
          if (got.col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, got.col);
            fails++;
          end
          if (got.value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, got.value);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("frame_last: expected %0d, got %0d", want.last, got.last);
            fails++;
          end
        end
      end
      if (pix.valid && pix.ready) predict_peak(pix.pixel_value);
    end
    fail_count <= fails;
    open_count <= peak_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  // receiver hold-off long enough to back up the whole pipeline
  localparam int LONG_HOLD     = 250;
  // quiet cycles after the last result before a register write or the verdict
  localparam int SETTLE_CYCLES = 8;
  // run-away guard limit, well above the slowest correct run
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 734;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [wnms_pkg::APB_ADDR_W-1:0] cfg_paddr;
  logic [wnms_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [wnms_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  int fail_count;
  int open_count;
  int cycle_count = 0;

  // idle ranges for both sides, 0 gives back-to-back transfers
  int tx_gap_hi = 5;
  int rx_stall_hi = 5;
  // set by the stimulus, cleared by the receiver once it starts the hold-off
  bit hold_req = 1'b0;

  // 3 x 7 frame, half window 1: centers along row 1 cover a tie kept,
  // a value beaten by a larger neighbor, the 255 peak, and a zero center
  wnms_pkg::pix_t probe_frame [0:20] = '{
    8'd10, 8'd10, 8'd10, 8'd0,   8'd0,   8'd0, 8'd0,
    8'd10, 8'd10, 8'd10, 8'd255, 8'd128, 8'd0, 8'd0,
    8'd10, 8'd10, 8'd10, 8'd0,   8'd0,   8'd0, 8'd0
  };

  wnms_pix_if pix_ch ();
  wnms_res_if res_ch ();

  window_non_maxima_suppression dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pix      (pix_ch),
    .out_res     (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predicts and compares; only hands back counts
  nms_result_check result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix         (pix_ch),
    .res         (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .fail_count  (fail_count),
    .open_count  (open_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // response mix: lots of small values and zeros so ties and flat areas
  // are common, plus the top of the range and fully random bytes
  function automatic wnms_pkg::pix_t draw_response();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return wnms_pkg::pix_t'($urandom_range(0, 3));
      4, 5:       return '0;
      6:          return 8'd255;
      7:          return wnms_pkg::pix_t'($urandom_range(254, 255));
      8:          return wnms_pkg::pix_t'($urandom_range(128, 255));
      default:    return wnms_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  // extra bits above a register field, which the block must ignore
  function automatic logic [wnms_pkg::APB_DATA_W-1:0] with_junk(int value, int field_w,
                                                                bit junk);
    logic [wnms_pkg::APB_DATA_W-1:0] word;
    word = wnms_pkg::APB_DATA_W'(value);
    if (junk) word = word | ($urandom() << field_w);
    return word;
  endfunction

  // one pixel transfer, after a random number of idle cycles
  task automatic feed_pixel(wnms_pkg::pix_t v);
    int gap;
    gap = (tx_gap_hi == 0) ? 0 : $urandom_range(0, tx_gap_hi);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid       <= 1'b1;
    pix_ch.pixel_value <= v;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // stop sending and wait until every predicted result has come out,
  // then give the pipeline time to empty of pixels that make no result
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup phase, access phase, then back to idle; pready is always high
  task automatic write_reg(wnms_pkg::reg_idx_t idx, logic [wnms_pkg::APB_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int hw, bit junk);
    settle();
    write_reg(wnms_pkg::REG_IMAGE_WIDTH,  with_junk(w, wnms_pkg::SIZE_W, junk));
    write_reg(wnms_pkg::REG_IMAGE_HEIGHT, with_junk(h, wnms_pkg::SIZE_W, junk));
    write_reg(wnms_pkg::REG_HALF_WINDOW,  with_junk(hw, wnms_pkg::HALF_CFG_W, junk));
  endtask

  // result side: random stall before each transfer, and one long hold-off
  // on request, counted here while the sender keeps going
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = (rx_stall_hi == 0) ? 0 : $urandom_range(0, rx_stall_hi);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready) && !hold_req);
    end
  end

  // stimulus
  initial begin
    int w;
    int h;
    int hw;
    int w_eff;
    int h_eff;
    int n;
    int random_pixels;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_value = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    random_pixels      = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset height and half window stay; 8 wide gives two rows of results
    // once the seventh row arrives with half window 3
    write_reg(wnms_pkg::REG_IMAGE_WIDTH, wnms_pkg::APB_DATA_W'(8));
    repeat (64) feed_pixel(draw_response());

    // hand-made frame: tie, beaten, peak, zero center, frame_last
    set_frame(7, 3, 1, 1'b0);
    foreach (probe_frame[i]) feed_pixel(probe_frame[i]);

    // zero width and height read as 1: every pixel is its own frame
    set_frame(0, 0, 0, 1'b0);
    repeat (5) feed_pixel(draw_response());

    // largest window, once through the clamp above the limit
    set_frame(9, 9, 7, 1'b0);
    repeat (81) feed_pixel(draw_response());
    set_frame(9, 9, 4, 1'b0);
    repeat (81) feed_pixel(8'd255);

    // back-pressure: every pixel makes a result, receiver holds off while
    // the sender streams back to back until the input stalls
    set_frame(8, 8, 0, 1'b0);
    tx_gap_hi = 0;
    hold_req = 1'b1;
    repeat (64) feed_pixel(draw_response());

    // random frames: mostly small sizes so results are dense, some larger
    // or out of range, some cut short so the next write lands mid-frame
    while (random_pixels < RANDOM_PIXELS) begin
      w  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      hw = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      w_eff = (w == 0) ? 1 : w;
      h_eff = (h == 0) ? 1 : h;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, w_eff * h_eff);
      else n = w_eff * h_eff * $urandom_range(1, 2);
      if (n > 240) n = 240;
      if (n > RANDOM_PIXELS - random_pixels) n = RANDOM_PIXELS - random_pixels;
      set_frame(w, h, hw, $urandom_range(0, 1) == 1);
      tx_gap_hi   = ($urandom_range(0, 3) == 0) ? 0 : 5;
      rx_stall_hi = ($urandom_range(0, 3) == 0) ? 0 : 5;
      repeat (n) feed_pixel(draw_response());
      random_pixels += n;
    end

    settle();
    if (fail_count == 0 && open_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
